@@ src/bba_pkg.sv @@
// Shared constants and types for the free-block bitmap allocator.
`default_nettype none

package bba_pkg;

	// Map word geometry: 32 map bits per memory word, MSB is the lowest block.
	localparam int WORD_BITS = 32;
	localparam int IDX_W     = 5;
	localparam logic [WORD_BITS-1:0] WORD_ONES = '1;
	localparam logic [WORD_BITS-1:0] WORD_TOP  = {1'b1, {(WORD_BITS-1){1'b0}}};

	// Block numbers and search limits (limit may reach 65536).
	localparam int BLK_W = 16;
	localparam int LIM_W = BLK_W + 1;

	// Defaults.
	localparam int MAP_BITS_DEF = 65536;
	localparam logic [BLK_W-1:0] TOTAL_RST = 16'd280;

	// Request codes.
	localparam logic [1:0] REQ_QUERY = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;
	localparam logic [1:0] REQ_FIRST = 2'd3;

	// Result of evaluating one map word during a first-fit scan.
	typedef struct packed {
		logic             hit;
		logic [BLK_W-1:0] blk;
	} scan_hit_t;

endpackage

`default_nettype wire

@@ src/bitmap_block_allocator.sv @@
// Top level of the first-fit free-block bitmap allocator.
// One map bit per block (1 = free), packed 32 to a word, most significant bit
// first, held in a single-port-write / single-port-read memory of
// ceil(MAP_BITS/32) words. After reset a clearing pass sets every word to all
// free; in_ready stays low meanwhile, and total_blocks writes are taken as
// usual. Requests are handled one at a time: the result word of a query or
// mark passes through the modify/write state and the output load before it is
// offered. First-fit allocate streams one map word per cycle through the
// single first-fit evaluator over the ceil(min(total_blocks, MAP_BITS)/32)
// words to search, and stops early at the word holding the first free block. A
// finished result waits in the output register while the next request is
// accepted; a further result waits in the sequencer until the receiver has
// taken the one in the output register.
`default_nettype none

module bitmap_block_allocator
	import bba_pkg::*;
#(
	parameter int MAP_BITS = MAP_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration
	input  wire logic             cfg_we,
	input  wire logic [BLK_W-1:0] cfg_wdata,
	// request channel
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       req_type,
	input  wire logic [BLK_W-1:0] block_num,
	// result channel
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  is_free,
	output logic                  alloc_ok,
	output logic [BLK_W-1:0]      alloc_block
);

	localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = $clog2(MAP_WORDS);
	localparam logic [LIM_W-1:0] MAP_LIM  = LIM_W'(MAP_BITS);
	localparam logic [AW-1:0]    LAST_ADR = AW'(MAP_WORDS - 1);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_MOD  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rd_q;

	logic [2:0]       state_q;
	logic [AW-1:0]    clr_q;
	logic [BLK_W-1:0] total_q;
	logic [1:0]       req_q;
	logic [BLK_W-1:0] blk_q;
	logic [LIM_W-1:0] lim_q;
	logic [AW:0]      iss_q;
	logic [AW-1:0]    ev_q;
	logic             pend_q;
	logic             res_free_q;
	logic             res_ok_q;
	logic [BLK_W-1:0] res_blk_q;
	logic             out_valid_q;
	logic             out_free_q;
	logic             out_ok_q;
	logic [BLK_W-1:0] out_blk_q;

	logic                 accept;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] sel;
	logic                 in_map;
	logic                 can_issue;
	logic [LIM_W-1:0]     ev_base;
	logic [LIM_W-1:0]     req_lim;
	logic                 out_load;
	scan_hit_t            scan;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign is_free     = out_free_q;
	assign alloc_ok    = out_ok_q;
	assign alloc_block = out_blk_q;

	// search limit: smaller of total_blocks and the map size
	assign req_lim   = ({1'b0, total_q} > MAP_LIM) ? MAP_LIM : {1'b0, total_q};
	assign ev_base   = LIM_W'({ev_q, IDX_W'(0)});
	assign can_issue = (LIM_W'({iss_q, IDX_W'(0)}) < lim_q);
	assign in_map    = ({1'b0, blk_q} < MAP_LIM);
	assign sel       = WORD_TOP >> blk_q[IDX_W-1:0];
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	bba_scan_eval #(
		.MAP_BITS(MAP_BITS)
	) u_eval (
		.word (rd_q),
		.base (ev_base),
		.limit(lim_q),
		.res  (scan)
	);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = blk_q[AW+IDX_W-1:IDX_W];
		mem_wdata = rd_q;
		mem_raddr = iss_q[AW-1:0];
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = WORD_ONES;
			end
			ST_IDLE: begin
				mem_raddr = block_num[AW+IDX_W-1:IDX_W];
			end
			ST_MOD: begin
				if (req_q == REQ_ALLOC) begin
					mem_we    = in_map;
					mem_wdata = rd_q & ~sel;
				end else if (req_q == REQ_FREE) begin
					mem_we    = in_map;
					mem_wdata = rd_q | sel;
				end
			end
			ST_SCAN: begin
				mem_we    = pend_q && scan.hit;
				mem_waddr = ev_q;
				mem_wdata = rd_q & ~(WORD_TOP >> scan.blk[IDX_W-1:0]);
			end
			default: begin
			end
		endcase
	end

	// map memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RST;
		end else if (cfg_we) begin
			total_q <= cfg_wdata;
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			iss_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						iss_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= (req_type == REQ_FIRST) ? ST_SCAN : ST_MOD;
					end
				end
				ST_MOD: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (pend_q && scan.hit) begin
						state_q <= ST_DONE;
					end else if (!pend_q && !can_issue) begin
						state_q <= ST_DONE;
					end else begin
						pend_q <= can_issue;
						if (can_issue) begin
							iss_q <= iss_q + (AW+1)'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and scan pointers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			blk_q <= block_num;
			lim_q <= req_lim;
		end
		if (state_q == ST_SCAN && can_issue) begin
			ev_q <= iss_q[AW-1:0];
		end
	end

	// result assembly
	always_ff @(posedge clk) begin
		if (accept) begin
			res_free_q <= 1'b0;
			res_ok_q   <= 1'b0;
			res_blk_q  <= '0;
		end else if (state_q == ST_MOD && req_q == REQ_QUERY) begin
			res_free_q <= in_map && ((rd_q & sel) != '0);
		end else if (state_q == ST_SCAN && pend_q && scan.hit) begin
			res_ok_q  <= 1'b1;
			res_blk_q <= scan.blk;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_free_q <= res_free_q;
			out_ok_q   <= res_ok_q;
			out_blk_q  <= res_blk_q;
		end
	end

endmodule

`default_nettype wire

@@ src/bba_scan_eval.sv @@
// First-fit evaluation of one map word against the search limit.
`default_nettype none

module bba_scan_eval
	import bba_pkg::*;
#(
	parameter int MAP_BITS = MAP_BITS_DEF
) (
	input  wire logic [WORD_BITS-1:0] word,
	input  wire logic [LIM_W-1:0]     base,
	input  wire logic [LIM_W-1:0]     limit,
	output scan_hit_t                 res
);

	localparam logic [LIM_W-1:0] MAP_LIM = LIM_W'(MAP_BITS);

	logic [LIM_W-1:0]     rem;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] cand;
	logic                 any;
	logic [IDX_W-1:0]     lz;

	// Keep only blocks below the limit (and inside the map), then find the first one.
	always_comb begin
		rem  = limit - base;
		mask = (rem >= LIM_W'(WORD_BITS)) ? WORD_ONES : ~(WORD_ONES >> rem[IDX_W-1:0]);
		if (base >= MAP_LIM) begin
			mask = '0;
		end
		cand = word & mask;
		any  = 1'b0;
		lz   = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!any && cand[WORD_BITS-1-i]) begin
				any = 1'b1;
				lz  = IDX_W'(i);
			end
		end
		res.hit = any;
		// base is word aligned, so the bit index fills the low bits
		res.blk = {base[BLK_W-1:IDX_W], lz};
	end

endmodule

`default_nettype wire
